@@ design/satrs_pkg.sv @@
// Shared types for the summed-area table rectangle-sum block.
package satrs_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BOUNDS     = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_ERR   = 2'd2
  } cmd_kind_t;

  localparam int CFG_IDX_W = 1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  typedef struct packed {
    cmd_kind_t kind;
    status_t   status;
    logic      has_up;
    logic      has_left;
    logic      first_col;
  } cmd_ctrl_t;

endpackage

@@ design/satrs_front.sv @@
// Front end: configuration registers, load counters and item classification.
module satrs_front #(
  parameter int MAX_DIM   = 64,
  parameter int CELL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [satrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [$clog2(MAX_DIM+1)-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_func,
  input  logic signed [CELL_BITS-1:0]           in_cell_value,
  input  logic [$clog2(MAX_DIM)-1:0]            in_top,
  input  logic [$clog2(MAX_DIM)-1:0]            in_left,
  input  logic [$clog2(MAX_DIM)-1:0]            in_bottom,
  input  logic [$clog2(MAX_DIM)-1:0]            in_right,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output satrs_pkg::cmd_ctrl_t                  push_ctrl,
  output logic [CELL_BITS-1:0]                  push_value,
  output logic [$clog2(MAX_DIM)-1:0]            push_row_hi,
  output logic [$clog2(MAX_DIM)-1:0]            push_row_lo,
  output logic [$clog2(MAX_DIM)-1:0]            push_col_hi,
  output logic [$clog2(MAX_DIM)-1:0]            push_col_lo
);
  import satrs_pkg::*;

  localparam int CoordW = $clog2(MAX_DIM);
  localparam int DimW   = $clog2(MAX_DIM + 1);

  logic [DimW-1:0]   grid_rows_r, grid_cols_r;
  logic [CoordW-1:0] load_row_r, load_col_r;
  logic              complete_r;

  logic [DimW-1:0]   rows_eff, cols_eff;
  logic [CoordW-1:0] row_cur, col_cur;
  logic              col_wrap, row_wrap, bad_bounds, accept, cfg_wr;

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && in_ready;

  always_comb begin
    if (grid_rows_r == '0) begin
      rows_eff = DimW'(1);
    end else if (grid_rows_r > DimW'(MAX_DIM)) begin
      rows_eff = DimW'(MAX_DIM);
    end else begin
      rows_eff = grid_rows_r;
    end
    if (grid_cols_r == '0) begin
      cols_eff = DimW'(1);
    end else if (grid_cols_r > DimW'(MAX_DIM)) begin
      cols_eff = DimW'(MAX_DIM);
    end else begin
      cols_eff = grid_cols_r;
    end
  end

  // a load after completion starts a new table at cell (0,0)
  assign row_cur  = complete_r ? '0 : load_row_r;
  assign col_cur  = complete_r ? '0 : load_col_r;
  assign col_wrap = (DimW'(col_cur) + DimW'(1)) >= cols_eff;
  assign row_wrap = (DimW'(row_cur) + DimW'(1)) >= rows_eff;

  assign bad_bounds = (in_top > in_bottom) || (in_left > in_right) ||
                      (DimW'(in_bottom) >= rows_eff) || (DimW'(in_right) >= cols_eff);

  always_comb begin
    push_value          = in_cell_value;
    push_ctrl.status    = ST_OK;
    push_ctrl.first_col = col_cur == '0;
    if (in_func == FUNC_LOAD) begin
      push_ctrl.kind     = CMD_LOAD;
      push_ctrl.has_up   = row_cur != '0;
      push_ctrl.has_left = 1'b0;
      push_row_hi        = row_cur;
      push_row_lo        = row_cur - CoordW'(1);
      push_col_hi        = col_cur;
      push_col_lo        = col_cur;
    end else begin
      push_ctrl.has_up   = in_top != '0;
      push_ctrl.has_left = in_left != '0;
      push_row_hi        = in_bottom;
      push_row_lo        = in_top - CoordW'(1);
      push_col_hi        = in_right;
      push_col_lo        = in_left - CoordW'(1);
      if (!complete_r) begin
        push_ctrl.kind   = CMD_ERR;
        push_ctrl.status = ST_INCOMPLETE;
      end else if (bad_bounds) begin
        push_ctrl.kind   = CMD_ERR;
        push_ctrl.status = ST_BOUNDS;
      end else begin
        push_ctrl.kind   = CMD_QUERY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= DimW'(MAX_DIM);
      grid_cols_r <= DimW'(MAX_DIM);
      load_row_r  <= '0;
      load_col_r  <= '0;
      complete_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_GRID_ROWS: begin
          grid_rows_r <= cfg_data;
        end
        REG_GRID_COLS: begin
          grid_cols_r <= cfg_data;
        end
        default: begin
        end
      endcase
      load_row_r <= '0;
      load_col_r <= '0;
      complete_r <= 1'b0;
    end else if (accept && in_func == FUNC_LOAD) begin
      if (col_wrap) begin
        load_col_r <= '0;
        load_row_r <= row_wrap ? '0 : row_cur + CoordW'(1);
        complete_r <= row_wrap;
      end else begin
        load_col_r <= col_cur + CoordW'(1);
        load_row_r <= row_cur;
        complete_r <= 1'b0;
      end
    end
  end

endmodule

@@ design/satrs_queue.sv @@
// Four-entry command queue between front end and table engine.
module satrs_queue #(
  parameter int W = 60
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  logic [W-1:0]    slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = count_r != (PtrW + 1)'(Depth);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (PtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (PtrW + 1)'(1);
      end
    end
  end

endmodule

@@ design/satrs_back.sv @@
// Table engine: prefix table memory, load accumulate and four-corner queries.
module satrs_back #(
  parameter int MAX_DIM   = 64,
  parameter int CELL_BITS = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           pop_valid,
  output logic                                           pop_ready,
  input  satrs_pkg::cmd_ctrl_t                           pop_ctrl,
  input  logic [CELL_BITS-1:0]                           pop_value,
  input  logic [$clog2(MAX_DIM)-1:0]                     pop_row_hi,
  input  logic [$clog2(MAX_DIM)-1:0]                     pop_row_lo,
  input  logic [$clog2(MAX_DIM)-1:0]                     pop_col_hi,
  input  logic [$clog2(MAX_DIM)-1:0]                     pop_col_lo,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [CELL_BITS+2*$clog2(MAX_DIM)-1:0]         out_sum,
  output satrs_pkg::status_t                             out_status
);
  import satrs_pkg::*;

  localparam int CoordW = $clog2(MAX_DIM);
  localparam int SumW   = CELL_BITS + 2 * CoordW;
  localparam int Depth  = MAX_DIM * MAX_DIM;
  localparam int AddrW  = $clog2(Depth);
  localparam int MulW   = 2 * CoordW + 1;

  function automatic logic [AddrW-1:0] cell_addr(input logic [CoordW-1:0] r,
                                                 input logic [CoordW-1:0] c);
    logic [MulW-1:0] full;
    full = MulW'(r) * MulW'(MAX_DIM) + MulW'(c);
    return full[AddrW-1:0];
  endfunction

  logic [SumW-1:0] mem [Depth];
  logic [SumW-1:0] rd_a_q, rd_b_q;

  logic            phase_r, phase_nxt;
  logic            go, out_free, res_busy;
  logic [AddrW-1:0] raddr_a, raddr_b;

  logic            ex_valid_r, ex_phase_r;
  cmd_ctrl_t       ex_ctrl_r;
  logic [CELL_BITS-1:0] ex_value_r;
  logic [AddrW-1:0] ex_waddr_r;
  logic            fwd_a_r, fwd_b_r;
  logic [SumW-1:0] fwd_data_r;

  logic [SumW-1:0] row_sum_r, partial_r;
  logic            out_valid_r;
  logic [SumW-1:0] out_sum_r;
  status_t         out_status_r;

  logic            ex_res, we;
  logic [SumW-1:0] data_a, data_b, cell_ext, row_sum_new, wdata, final_sum;

  assign out_free = !out_valid_r || out_ready;
  assign ex_res   = ex_valid_r &&
                    (ex_ctrl_r.kind == CMD_ERR || (ex_ctrl_r.kind == CMD_QUERY && ex_phase_r));
  assign res_busy = ex_res;

  // issue: one read slot for a load or an error command, two for a query
  always_comb begin
    go        = 1'b0;
    pop_ready = 1'b0;
    phase_nxt = phase_r;
    raddr_a   = cell_addr(pop_row_lo, pop_col_hi);
    raddr_b   = cell_addr(pop_row_hi, pop_col_lo);
    if (pop_valid) begin
      unique case (pop_ctrl.kind)
        CMD_LOAD: begin
          go        = 1'b1;
          pop_ready = 1'b1;
        end
        CMD_ERR: begin
          go        = out_free && !res_busy;
          pop_ready = go;
        end
        CMD_QUERY: begin
          if (!phase_r) begin
            go        = out_free && !res_busy;
            phase_nxt = go;
            raddr_a   = cell_addr(pop_row_hi, pop_col_hi);
            raddr_b   = cell_addr(pop_row_hi, pop_col_lo);
          end else begin
            go        = 1'b1;
            pop_ready = 1'b1;
            phase_nxt = 1'b0;
            raddr_a   = cell_addr(pop_row_lo, pop_col_hi);
            raddr_b   = cell_addr(pop_row_lo, pop_col_lo);
          end
        end
        default: begin
          pop_ready = 1'b1;
        end
      endcase
    end
  end

  // execute
  always_comb begin
    data_a      = fwd_a_r ? fwd_data_r : rd_a_q;
    data_b      = fwd_b_r ? fwd_data_r : rd_b_q;
    cell_ext    = {{(SumW - CELL_BITS){ex_value_r[CELL_BITS-1]}}, ex_value_r};
    row_sum_new = (ex_ctrl_r.first_col ? '0 : row_sum_r) + cell_ext;
    wdata       = row_sum_new + (ex_ctrl_r.has_up ? data_a : '0);
    we          = ex_valid_r && ex_ctrl_r.kind == CMD_LOAD;
    final_sum   = partial_r - (ex_ctrl_r.has_up ? data_a : '0) +
                  ((ex_ctrl_r.has_up && ex_ctrl_r.has_left) ? data_b : '0);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ex_waddr_r] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    ex_ctrl_r  <= pop_ctrl;
    ex_phase_r <= phase_r;
    ex_value_r <= pop_value;
    ex_waddr_r <= cell_addr(pop_row_hi, pop_col_hi);
    // write in flight hits the address being read
    fwd_a_r    <= we && ex_waddr_r == raddr_a;
    fwd_b_r    <= we && ex_waddr_r == raddr_b;
    fwd_data_r <= wdata;
    if (we) begin
      row_sum_r <= row_sum_new;
    end
    if (ex_valid_r && ex_ctrl_r.kind == CMD_QUERY && !ex_phase_r) begin
      partial_r <= data_a - (ex_ctrl_r.has_left ? data_b : '0);
    end
    if (ex_res) begin
      out_sum_r    <= (ex_ctrl_r.kind == CMD_ERR) ? '0 : final_sum;
      out_status_r <= (ex_ctrl_r.kind == CMD_ERR) ? ex_ctrl_r.status : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      ex_valid_r <= go;
      if (ex_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sum    = out_sum_r;
  assign out_status = out_status_r;

endmodule

@@ design/summed_area_table_rect_sum.sv @@
// Summed-area table with inclusive rectangle-sum queries.
// Loads: one beat per cycle while the queue has room; a cell is written to the table
//   from the execute register. Queries: two read phases of the dual-read table memory;
//   the next starts once execute and the single output register are free of results.
// Reset (rst_n, synchronous): grid size MAX_DIM x MAX_DIM, load restarts, table incomplete,
//   queue and output emptied; table contents stay undefined until loaded.
module summed_area_table_rect_sum #(
  parameter int MAX_DIM   = 64,
  parameter int CELL_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [satrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [$clog2(MAX_DIM+1)-1:0]           cfg_data,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // cell_value, top_row, left_col, bottom_row, right_col
  input  logic [((CELL_BITS+4*$clog2(MAX_DIM)+7)/8)*8-1:0] in_tdata,
  // func
  input  logic [0:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // rect_sum
  output logic [((CELL_BITS+2*$clog2(MAX_DIM)+7)/8)*8-1:0] out_tdata,
  // status
  output logic [1:0]                             out_tuser
);
  import satrs_pkg::*;

  localparam int CoordW = $clog2(MAX_DIM);
  localparam int SumW   = CELL_BITS + 2 * CoordW;
  localparam int OutW   = ((SumW + 7) / 8) * 8;
  localparam int QW     = $bits(cmd_ctrl_t) + CELL_BITS + 4 * CoordW;

  logic                 f_valid, f_ready, q_valid, q_ready;
  cmd_ctrl_t            f_ctrl, q_ctrl;
  logic [CELL_BITS-1:0] f_value, q_value;
  logic [CoordW-1:0]    f_row_hi, f_row_lo, f_col_hi, f_col_lo;
  logic [CoordW-1:0]    q_row_hi, q_row_lo, q_col_hi, q_col_lo;
  logic [QW-1:0]        q_data;
  logic [SumW-1:0]      out_sum;
  status_t              out_status;

  satrs_front #(
    .MAX_DIM   (MAX_DIM),
    .CELL_BITS (CELL_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_func       (in_tuser[0]),
    .in_cell_value (in_tdata[CELL_BITS-1:0]),
    .in_top        (in_tdata[CELL_BITS +: CoordW]),
    .in_left       (in_tdata[CELL_BITS + CoordW +: CoordW]),
    .in_bottom     (in_tdata[CELL_BITS + 2 * CoordW +: CoordW]),
    .in_right      (in_tdata[CELL_BITS + 3 * CoordW +: CoordW]),
    .push_valid    (f_valid),
    .push_ready    (f_ready),
    .push_ctrl     (f_ctrl),
    .push_value    (f_value),
    .push_row_hi   (f_row_hi),
    .push_row_lo   (f_row_lo),
    .push_col_hi   (f_col_hi),
    .push_col_lo   (f_col_lo)
  );

  satrs_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctrl, f_value, f_row_hi, f_row_lo, f_col_hi, f_col_lo}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign {q_ctrl, q_value, q_row_hi, q_row_lo, q_col_hi, q_col_lo} = q_data;

  satrs_back #(
    .MAX_DIM   (MAX_DIM),
    .CELL_BITS (CELL_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_ctrl   (q_ctrl),
    .pop_value  (q_value),
    .pop_row_hi (q_row_hi),
    .pop_row_lo (q_row_lo),
    .pop_col_hi (q_col_hi),
    .pop_col_lo (q_col_lo),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sum    (out_sum),
    .out_status (out_status)
  );

  assign out_tdata = OutW'(out_sum);
  assign out_tuser = out_status;

  a_err_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_status != ST_OK |-> out_sum == '0)
    else $error("flagged result carries a nonzero sum");

  a_err_cmd_status: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ctrl.kind == CMD_ERR |-> q_ctrl.status != ST_OK)
    else $error("error command queued with ok status");

  a_query_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ctrl.kind != CMD_ERR |-> q_ctrl.status == ST_OK)
    else $error("load or query command queued with error status");

endmodule

@@ bench/tb_summed_area_table_rect_sum.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the summed-area table rectangle-sum block.
module tb_summed_area_table_rect_sum;
  import satrs_pkg::*;

  localparam int DIM = 64;

  typedef struct {
    logic        func;
    logic [15:0] cell_val;
    logic [5:0]  top;
    logic [5:0]  left;
    logic [5:0]  bottom;
    logic [5:0]  right;
  } grid_beat_t;

  typedef struct {
    logic [27:0] sum;
    status_t     status;
  } rect_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  // predicted table and load state
  logic [27:0] sat_mem [0:DIM*DIM-1];
  logic [27:0] row_acc;
  int          ld_row;
  int          ld_col;
  bit          tbl_done;
  logic [6:0]  rows_reg;
  logic [6:0]  cols_reg;

  grid_beat_t   pending_beats[$];
  rect_result_t expected_sums[$];
  grid_beat_t   beat_on_bus;
  int           send_gap_pct = 0;
  int           stall_pct = 0;
  int           errors = 0;
  int           item_count = 0;

  summed_area_table_rect_sum i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // cell_value, top_row, left_col, bottom_row, right_col
    .in_tuser   (in_tuser),   // func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // rect_sum
    .out_tuser  (out_tuser)   // status
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_dim(input logic [6:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic logic [27:0] sat_at(input int r, input int c);
    return sat_mem[r * DIM + c];
  endfunction

  task automatic restart_table();
    row_acc = '0;
    ld_row = 0;
    ld_col = 0;
    tbl_done = 1'b0;
  endtask

  task automatic predict_beat(input grid_beat_t b);
    int           nr;
    int           nc;
    logic [27:0]  s;
    rect_result_t r;
    nr = eff_dim(rows_reg);
    nc = eff_dim(cols_reg);
    if (b.func == FUNC_LOAD) begin
      if (tbl_done) restart_table();
      row_acc = row_acc + {{12{b.cell_val[15]}}, b.cell_val};
      s = row_acc;
      if (ld_row > 0) s = s + sat_at(ld_row - 1, ld_col);
      sat_mem[ld_row * DIM + ld_col] = s;
      ld_col++;
      if (ld_col >= nc) begin
        ld_col = 0;
        row_acc = '0;
        ld_row++;
        if (ld_row >= nr) begin
          ld_row = 0;
          tbl_done = 1'b1;
        end
      end
    end else begin
      r.sum = '0;
      if (!tbl_done) begin
        r.status = ST_INCOMPLETE;
      end else if (b.top > b.bottom || b.left > b.right || b.bottom >= nr || b.right >= nc) begin
        r.status = ST_BOUNDS;
      end else begin
        r.status = ST_OK;
        s = sat_at(b.bottom, b.right);
        if (b.left > 0) s = s - sat_at(b.bottom, b.left - 1);
        if (b.top > 0) s = s - sat_at(b.top - 1, b.right);
        if (b.top > 0 && b.left > 0) s = s + sat_at(b.top - 1, b.left - 1);
        r.sum = s;
      end
      expected_sums.push_back(r);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_beat(beat_on_bus);
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          beat_on_bus = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= beat_on_bus.func;
          in_tdata <= {beat_on_bus.right, beat_on_bus.bottom, beat_on_bus.left,
                       beat_on_bus.top, beat_on_bus.cell_val};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    rect_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_sums.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual sum=%0d status=%0d",
                   $time, $signed(out_tdata[27:0]), out_tuser);
        end else begin
          want = expected_sums.pop_front();
          if (out_tdata[27:0] !== want.sum || out_tuser !== want.status) begin
            errors++;
            $display("%0t: mismatch, expected sum=%0d status=%0d, actual sum=%0d status=%0d",
                     $time, $signed(want.sum), want.status,
                     $signed(out_tdata[27:0]), out_tuser);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_mode(input int k);
    case (k)
      1: begin
        send_gap_pct = 46;
        stall_pct = 0;
      end
      2: begin
        send_gap_pct = 0;
        stall_pct = 46;
      end
      3: begin
        send_gap_pct = 11;
        stall_pct = 11;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  function automatic logic [15:0] rand_cell();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_load(input logic [15:0] v);
    grid_beat_t b;
    b.func = FUNC_LOAD;
    b.cell_val = v;
    b.top = 6'($urandom);
    b.left = 6'($urandom);
    b.bottom = 6'($urandom);
    b.right = 6'($urandom);
    pending_beats.push_back(b);
    item_count++;
  endtask

  task automatic push_query(input int t, input int l, input int bt, input int rt);
    grid_beat_t b;
    b.func = FUNC_QUERY;
    b.cell_val = 16'($urandom);
    b.top = 6'(t);
    b.left = 6'(l);
    b.bottom = 6'(bt);
    b.right = 6'(rt);
    pending_beats.push_back(b);
    item_count++;
  endtask

  task automatic push_rand_query(input int nr, input int nc);
    int t;
    int l;
    if ($urandom_range(4) == 0) begin
      push_query($urandom_range(63), $urandom_range(63), $urandom_range(63),
                 $urandom_range(63));
    end else begin
      t = $urandom_range(nr - 1, 0);
      l = $urandom_range(nc - 1, 0);
      push_query(t, l, $urandom_range(nr - 1, t), $urandom_range(nc - 1, l));
    end
  endtask

  // waits for the block to go quiet, including trailing table writes
  task automatic drain();
    while (pending_beats.size() != 0 || in_tvalid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_grid(input logic [0:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GRID_ROWS) rows_reg = val;
    else cols_reg = val;
    restart_table();
    @(negedge clk);
  endtask

  task automatic run_table(input logic [6:0] rows_raw, input logic [6:0] cols_raw,
                           input int nq);
    int nr;
    int nc;
    int k;
    if ($urandom_range(1)) begin
      write_grid(REG_GRID_ROWS, rows_raw);
      write_grid(REG_GRID_COLS, cols_raw);
    end else begin
      write_grid(REG_GRID_COLS, cols_raw);
      write_grid(REG_GRID_ROWS, rows_raw);
    end
    nr = eff_dim(rows_raw);
    nc = eff_dim(cols_raw);
    if ($urandom_range(3) == 0) push_rand_query(nr, nc);
    // abandoned partial table, restarted by a register write
    if ($urandom_range(5) == 0 && nr * nc > 1) begin
      k = $urandom_range(nr * nc - 1, 1);
      repeat (k) push_load(rand_cell());
      push_rand_query(nr, nc);
      drain();
      write_grid(REG_GRID_COLS, cols_raw);
    end
    k = $urandom_range(nr * nc - 1, 0);
    for (int i = 0; i < nr * nc; i++) begin
      push_load(rand_cell());
      if (i == k && i != nr * nc - 1 && $urandom_range(2) == 0) push_rand_query(nr, nc);
    end
    push_query(0, 0, nr - 1, nc - 1);
    repeat (nq) push_rand_query(nr, nc);
    // load after completion begins a new table
    if ($urandom_range(3) == 0) begin
      push_load(rand_cell());
      push_rand_query(nr, nc);
      repeat (nr * nc - 1) push_load(rand_cell());
      repeat (4) push_rand_query(nr, nc);
    end
  endtask

  initial begin
    int round;
    logic [6:0] r;
    logic [6:0] c;
    rows_reg = 7'd64;
    cols_reg = 7'd64;
    restart_table();
    set_mode(0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_query(0, 0, 0, 0);
    drain();
    write_grid(REG_GRID_ROWS, 7'd2);
    write_grid(REG_GRID_COLS, 7'd3);
    push_load(16'h7FFF);
    push_load(16'h8000);
    push_load(16'h0000);
    push_load(16'hFFFF);
    push_load(16'h0001);
    push_query(0, 0, 1, 2);
    push_load(16'h5555);
    push_query(0, 0, 1, 2);
    push_query(0, 0, 0, 0);
    push_query(1, 2, 1, 2);
    push_query(1, 1, 1, 2);
    push_query(1, 0, 0, 2);
    push_query(0, 2, 1, 1);
    push_query(0, 0, 2, 2);
    push_query(0, 0, 1, 3);
    push_query(63, 63, 63, 63);
    push_load(16'h7FFF);
    push_query(0, 0, 0, 0);
    drain();

    // size extremes, out-of-range writes included
    set_mode(1);
    run_table(7'd0, 7'd127, 8);
    drain();
    set_mode(2);
    run_table(7'd64, 7'd1, 8);
    drain();
    set_mode(3);
    run_table(7'd127, 7'd2, 10);
    drain();
    set_mode(0);
    run_table(7'd1, 7'd1, 4);
    drain();

    round = 0;
    while (item_count < 870) begin
      set_mode(round % 4);
      case ($urandom_range(9))
        0: begin
          r = $urandom_range(1) ? 7'd64 : 7'd127;
          c = 7'($urandom_range(2, 1));
        end
        1: begin
          r = 7'($urandom_range(2, 0));
          c = $urandom_range(1) ? 7'd64 : 7'd100;
        end
        default: begin
          r = 7'($urandom_range(8, 1));
          c = 7'($urandom_range(8, 1));
        end
      endcase
      run_table(r, c, $urandom_range(16, 6));
      drain();
      round++;
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
